/* src/separable_blur_strip_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the separable blur strip
// Clocked implication checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BLUR_STRIP_ASSERT_SVH
`define SEPARABLE_BLUR_STRIP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("separable_blur_strip: same-cycle check failed");
// Next-cycle implication.
`define SBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("separable_blur_strip: next-cycle check failed");
`else
`define SBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/sbs_pkg.sv */
// ----------------------------------------------------------------------------
// sbs_pkg
// Types, codes and helpers of the separable blur strip.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int CH_W   = 8;
  localparam int WGT_W  = 16;
  localparam int ACC_W  = 29;  // 23 taps of 16b weight times 8b channel
  localparam int WSUM_W = 21;  // 23 taps of 16b weight

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_STRIP_ROWS    = 3'd1,
    CFG_FIRST_OUT_ROW = 3'd2,
    CFG_OUT_ROWS      = 3'd3,
    CFG_RADIUS        = 3'd4,
    CFG_WEIGHTS_LOW   = 3'd5,
    CFG_WEIGHTS_MID   = 3'd6,
    CFG_WEIGHTS_HIGH  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SETUP,
    ST_TAPS,
    ST_TAIL,
    ST_NORM,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [8:0] out_column;
    logic [6:0] out_row;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last;
  } out_item_t;

  // Picks weight lane idx out of the three 64-bit weight registers.
  function automatic logic [WGT_W-1:0] weight_lane(input logic [63:0] lo,
                                                   input logic [63:0] mid,
                                                   input logic [63:0] hi,
                                                   input logic [3:0]  idx);
    logic [WGT_W-1:0] w;
    case (idx)
      4'd0:    w = lo[15:0];
      4'd1:    w = lo[31:16];
      4'd2:    w = lo[47:32];
      4'd3:    w = lo[63:48];
      4'd4:    w = mid[15:0];
      4'd5:    w = mid[31:16];
      4'd6:    w = mid[47:32];
      4'd7:    w = mid[63:48];
      4'd8:    w = hi[15:0];
      4'd9:    w = hi[31:16];
      4'd10:   w = hi[47:32];
      4'd11:   w = hi[63:48];
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* src/separable_blur_strip.sv */
// ----------------------------------------------------------------------------
// separable_blur_strip
// Strip-based separable RGB blur with a load/drain command interface.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one command. A load (command 0)
// stores the next pixel of the strip in raster order; it stays busy through
// the bit-serial split of the load position into row and column. The load
// that completes a row also runs the horizontal pass of that row: one
// strip-memory read per tap plus a bit-serial divide per pixel. A drain
// (command 1) produces one blurred pixel: out_valid rises after the position
// split, one horizontal-memory read per vertical tap and the normalizing
// divide. The result is shown on out_item for exactly one cycle and cannot be
// held off, so the receiver must take it when out_valid is high. busy is low
// again in the cycle out_valid is high. Both stores are plain single-port-write
// memories with no reset; draining pixels whose rows were never loaded returns
// undefined data. Write the configuration only while busy is low; new values
// take effect from the next command.
// ----------------------------------------------------------------------------
`include "separable_blur_strip_assert.svh"

module separable_blur_strip #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_ROWS   = 128,
  parameter int MAX_RADIUS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sbs_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sbs_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  import sbs_pkg::*;

  // Address and counter widths follow from the strip limits.
  localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 1;                      // positions reach DEPTH
  localparam int WW    = $clog2(MAX_WIDTH + 1);       // effective width
  localparam int RW    = $clog2(MAX_ROWS + 1);        // effective row counts
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DSW   = (YW > 1) ? $clog2(YW) : 1;
  localparam int VRW   = ((YW > 7) ? YW : 7) + 1;     // vertical output row
  localparam int CW0   = (XW > VRW) ? XW : VRW;
  localparam int CW    = ((CW0 > 5) ? CW0 : 5) + 1;   // position plus tap index

  // Configuration registers.
  logic [9:0]  image_width_r;
  logic [7:0]  strip_rows_r;
  logic [6:0]  first_out_row_r;
  logic [7:0]  out_rows_r;
  logic [3:0]  radius_r;
  logic [63:0] weights_low_r;
  logic [63:0] weights_mid_r;
  logic [63:0] weights_high_r;

  // Clamped register values.
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_rows;
  logic [RW-1:0] eff_out;
  logic [3:0]    eff_rad;

  // Sequencer and positions.
  state_t         state_r, state_nxt;
  logic           cmd_r;
  logic [23:0]    pix_r;
  logic [PW-1:0]  lp_r;           // load position
  logic [PW-1:0]  dp_r;           // drain position
  logic [PW-1:0]  dpe_r;          // drain position used by this drain
  logic [PW-1:0]  total_load_r;
  logic [PW-1:0]  total_out_r;
  logic [PW-1:0]  rem_r;
  logic [YW-1:0]  quo_r;
  logic [DSW-1:0] dstep_r;
  logic [PW-1:0]  div_sh;

  // Tap loop.
  logic             hmode_r;      // 1: horizontal pass, 0: vertical drain
  logic [CW-1:0]    pos_r;        // column (horizontal) or strip row (vertical)
  logic [XW-1:0]    col_r;
  logic [AW-1:0]    base_r;
  logic [4:0]       j_r;
  logic             tv_r;
  logic [WGT_W-1:0] tw_r;
  logic [CW:0]      p_raw;
  logic [CW:0]      p_off;
  logic [CW:0]      tap_limit;
  logic             tap_ok;
  logic [4:0]       tap_last;
  logic [3:0]       tap_dist;
  logic [AW-1:0]    tap_addr;
  logic [23:0]      tap_pix;

  // Accumulators, reused as remainders by the normalizing divide.
  logic [ACC_W-1:0]  acc_r [3];
  logic [WSUM_W-1:0] wsum_r;
  logic [CH_W-1:0]   nq_r [3];
  logic [2:0]        nstep_r;
  logic [ACC_W:0]    norm_sh;
  logic [23:0]       rgb_res;

  // Memories.
  logic [23:0]   strip_mem [DEPTH];
  logic [23:0]   horiz_mem [DEPTH];
  logic [23:0]   s_rd_r;
  logic [23:0]   h_rd_r;
  logic          s_we;
  logic          h_we;
  logic [AW-1:0] h_waddr;

  logic      accept;
  out_item_t out_item_r;
  logic      out_valid_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 10'd512;
      strip_rows_r    <= 8'd128;
      first_out_row_r <= 7'd0;
      out_rows_r      <= 8'd128;
      radius_r        <= 4'd0;
      weights_low_r   <= 64'd32768;
      weights_mid_r   <= 64'd0;
      weights_high_r  <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata[9:0];
        CFG_STRIP_ROWS:    strip_rows_r    <= cfg_wdata[7:0];
        CFG_FIRST_OUT_ROW: first_out_row_r <= cfg_wdata[6:0];
        CFG_OUT_ROWS:      out_rows_r      <= cfg_wdata[7:0];
        CFG_RADIUS:        radius_r        <= cfg_wdata[3:0];
        CFG_WEIGHTS_LOW:   weights_low_r   <= cfg_wdata;
        CFG_WEIGHTS_MID:   weights_mid_r   <= cfg_wdata;
        CFG_WEIGHTS_HIGH:  weights_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the width, row counts and radius to their legal ranges, as the datapath expects.
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    if (strip_rows_r == '0) begin
      eff_rows = RW'(1);
    end else if (int'(strip_rows_r) > MAX_ROWS) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(strip_rows_r);
    end
    if (out_rows_r == '0) begin
      eff_out = RW'(1);
    end else if (int'(out_rows_r) > MAX_ROWS) begin
      eff_out = RW'(MAX_ROWS);
    end else begin
      eff_out = RW'(out_rows_r);
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      eff_rad = 4'(MAX_RADIUS);
    end else begin
      eff_rad = radius_r;
    end
  end

  // The pixel totals are registered every cycle. A command transfer is
  // followed by the prepare state, so the totals already reflect any
  // configuration write made just before it.
  always_ff @(posedge clk) begin
    total_load_r <= PW'(eff_w) * PW'(eff_rows);
    total_out_r  <= PW'(eff_w) * PW'(eff_out);
  end

  // --------------------------------------------------------------------------
  // Tap address generation. The tap offset runs from -radius to +radius as
  // j - radius; an offset position outside [0, limit) is skipped.
  // --------------------------------------------------------------------------
  always_comb begin
    tap_last  = {eff_rad, 1'b0};
    p_raw     = (CW + 1)'(pos_r) + (CW + 1)'(j_r);
    p_off     = p_raw - (CW + 1)'(eff_rad);
    tap_limit = hmode_r ? (CW + 1)'(eff_w) : (CW + 1)'(eff_rows);
    tap_ok    = (p_raw >= (CW + 1)'(eff_rad)) && (p_off < tap_limit);
    tap_dist  = (j_r >= {1'b0, eff_rad}) ? 4'(j_r - {1'b0, eff_rad})
                                         : 4'({1'b0, eff_rad} - j_r);
    if (hmode_r) begin
      tap_addr = base_r + AW'(p_off);
    end else begin
      tap_addr = AW'(col_r) + AW'(AW'(p_off) * AW'(eff_w));
    end
    tap_pix = hmode_r ? s_rd_r : h_rd_r;
  end

  // Restoring division steps: position by width, then sums by weight total.
  assign div_sh  = PW'(eff_w) << dstep_r;
  assign norm_sh = (ACC_W + 1)'(wsum_r) << nstep_r;
  assign rgb_res = (wsum_r == '0) ? 24'd0 : {nq_r[0], nq_r[1], nq_r[2]};

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (cmd_r == CMD_LOAD && lp_r >= total_load_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dstep_r == '0) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (cmd_r == CMD_LOAD && rem_r != PW'(eff_w - WW'(1))) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_TAPS;
        end
      end
      ST_TAPS: begin
        if (j_r == tap_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: state_nxt = ST_NORM;
      ST_NORM: begin
        if (nstep_r == '0) begin
          state_nxt = hmode_r ? ST_STORE : ST_EMIT;
        end
      end
      ST_STORE: begin
        if (pos_r == CW'(eff_w - WW'(1))) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_TAPS;
        end
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy    = 1'b1;
    s_we    = 1'b0;
    h_we    = 1'b0;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_SETUP: s_we = (cmd_r == CMD_LOAD);
      ST_STORE: h_we = 1'b1;
      default:  ;
    endcase
  end

  assign accept  = start && !busy;
  assign h_waddr = base_r + AW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: one write and one registered read per cycle each.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_we) begin
      strip_mem[AW'(lp_r)] <= pix_r;
    end
    s_rd_r <= strip_mem[tap_addr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      horiz_mem[h_waddr] <= rgb_res;
    end
    h_rd_r <= horiz_mem[tap_addr];
  end

  // --------------------------------------------------------------------------
  // Positions and the result strobe
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= '0;
      dp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
      if (state_r == ST_SETUP && cmd_r == CMD_LOAD) begin
        lp_r <= lp_r + PW'(1);
      end
      if (state_r == ST_EMIT) begin
        if (dpe_r == total_out_r - PW'(1)) begin
          dp_r <= '0;
          lp_r <= '0;
        end else begin
          dp_r <= dpe_r + PW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      pix_r <= {in_item.red_in, in_item.green_in, in_item.blue_in};
    end

    // Split the position into row and column, one quotient bit a cycle.
    if (state_r == ST_PREP) begin
      dpe_r   <= (dp_r >= total_out_r) ? '0 : dp_r;
      rem_r   <= (cmd_r == CMD_LOAD) ? lp_r : ((dp_r >= total_out_r) ? '0 : dp_r);
      quo_r   <= '0;
      dstep_r <= DSW'(YW - 1);
    end
    if (state_r == ST_DIV) begin
      if (rem_r >= div_sh) begin
        rem_r          <= rem_r - div_sh;
        quo_r[dstep_r] <= 1'b1;
      end
      if (dstep_r != '0) begin
        dstep_r <= dstep_r - DSW'(1);
      end
    end

    // Prepare a tap sweep: a row's horizontal pass or one vertical drain.
    if (state_r == ST_SETUP) begin
      if (cmd_r == CMD_LOAD) begin
        hmode_r <= 1'b1;
        base_r  <= AW'(lp_r - rem_r);
        pos_r   <= '0;
      end else begin
        hmode_r <= 1'b0;
        pos_r   <= CW'(first_out_row_r) + CW'(quo_r);
        col_r   <= XW'(rem_r);
      end
    end
    if (state_r == ST_STORE) begin
      pos_r <= pos_r + CW'(1);
    end

    // Tap sweep; the read data, tv_r and tw_r are registered together, in the cycle after the tap is issued.
    if (state_r == ST_SETUP || state_r == ST_STORE) begin
      j_r    <= '0;
      wsum_r <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end else if (tv_r) begin
      wsum_r <= wsum_r + WSUM_W'(tw_r);
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'(ACC_W'(tw_r) * ACC_W'(tap_pix[23 - 8 * c -: 8]));
      end
    end else if (state_r == ST_NORM) begin
      for (int c = 0; c < 3; c++) begin
        if ((ACC_W + 1)'(acc_r[c]) >= norm_sh) begin
          acc_r[c]         <= ACC_W'((ACC_W + 1)'(acc_r[c]) - norm_sh);
          nq_r[c][nstep_r] <= 1'b1;
        end
      end
    end

    if (state_r == ST_TAPS) begin
      tv_r <= tap_ok;
      tw_r <= weight_lane(weights_low_r, weights_mid_r, weights_high_r, tap_dist);
      j_r  <= j_r + 5'd1;
    end else begin
      tv_r <= 1'b0;
    end

    if (state_r == ST_TAIL) begin
      nstep_r <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        nq_r[c] <= '0;
      end
    end else if (state_r == ST_NORM && nstep_r != '0) begin
      nstep_r <= nstep_r - 3'd1;
    end

    if (state_r == ST_EMIT) begin
      out_item_r.out_column <= 9'(col_r);
      out_item_r.out_row    <= 7'(pos_r);
      out_item_r.red_out    <= rgb_res[23:16];
      out_item_r.green_out  <= rgb_res[15:8];
      out_item_r.blue_out   <= rgb_res[7:0];
      out_item_r.last       <= (dpe_r == total_out_r - PW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SBS_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  `SBS_ASSERT_IMP(a_valid_from_emit, clk, rst_n, out_valid, $past(state_r == ST_EMIT))
  `SBS_ASSERT_IMP(a_one_store_write, clk, rst_n, s_we, !h_we)
  `SBS_ASSERT_IMP(a_valid_idle, clk, rst_n, out_valid, !busy)

endmodule

/* verif/separable_blur_strip_tb.sv */
// ----------------------------------------------------------------------------
// separable_blur_strip_tb
// Self-checking bench for the separable blur strip. Strips of pixels are
// loaded and drained under a series of register settings, and every drained
// pixel is checked against a behavioral blur kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module separable_blur_strip_tb;
  import sbs_pkg::*;

  localparam int STORE_DEPTH = 512 * 128;
  localparam int CYCLE_LIMIT = 2000000;

  // One pending command. A held command is not issued until every expected
  // pixel has arrived, which forces the block to drain completely.
  typedef struct {
    in_item_t item;
    bit       hold;
  } pending_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           in_item = '0;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  pending_cmd_t       cmd_queue[$];
  out_item_t          expected_pixels[$];
  int                 fail_count = 0;
  int                 item_count = 0;
  int unsigned        cycle_count = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;

  // Register mirror, at the register widths so that writes truncate.
  logic [9:0]         width_reg;
  logic [7:0]         rows_reg;
  logic [6:0]         first_row_reg;
  logic [7:0]         out_rows_reg;
  logic [3:0]         radius_reg;
  logic [63:0]        weight_reg[3];

  // Mirror of the pixel stores and the two positions.
  logic [23:0]        strip_mem[STORE_DEPTH];
  logic [23:0]        hblur_mem[STORE_DEPTH];
  int unsigned        load_pos;
  int unsigned        drain_pos;

  separable_blur_strip dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Effective register values: each is clamped into its legal range.
  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp(width_reg, 1, 512);
  endfunction

  function automatic int unsigned eff_rows();
    return clamp(rows_reg, 1, 128);
  endfunction

  // Symmetric weighted average along one axis. Taps outside 0..limit-1 are
  // skipped, and the sum is divided by the weights of the taps actually used.
  function automatic logic [23:0] blur_axis(bit vertical, int unsigned base,
                                           int pos, int limit, int unsigned stride);
    longint unsigned acc[3];
    longint unsigned wsum;
    longint unsigned wgt;
    longint unsigned q;
    int              rad;
    int              p;
    int unsigned     ak;
    int unsigned     idx;
    logic [23:0]     pix;
    logic [23:0]     res;
    acc = '{0, 0, 0};
    wsum = 0;
    res = '0;
    rad = clamp(radius_reg, 0, 11);
    for (int k = -rad; k <= rad; k++) begin
      p = pos + k;
      ak = (k < 0) ? -k : k;
      if (p < 0 || p >= limit) continue;
      idx = base + p * stride;
      if (idx >= STORE_DEPTH) continue;
      wgt = (weight_reg[ak / 4] >> ((ak % 4) * 16)) & 64'hFFFF;
      pix = vertical ? hblur_mem[idx] : strip_mem[idx];
      for (int c = 0; c < 3; c++) acc[c] += wgt * pix[16 - 8 * c +: 8];
      wsum += wgt;
    end
    if (wsum == 0) return '0;
    for (int c = 0; c < 3; c++) begin
      q = acc[c] / wsum;
      res[16 - 8 * c +: 8] = (q > 255) ? 8'd255 : q[7:0];
    end
    return res;
  endfunction

  // Works out what one accepted command does. A load may finish a row and
  // trigger its horizontal pass; a drain yields exactly one expected pixel.
  function automatic void predict_command(in_item_t cmd);
    int unsigned w;
    int unsigned total;
    int unsigned row;
    int unsigned x;
    logic [23:0] px;
    out_item_t   exp_pix;
    w = eff_width();
    if (cmd.command == CMD_LOAD) begin
      total = w * eff_rows();
      if (load_pos >= total) return;  // loads past the strip are dropped
      strip_mem[load_pos] = {cmd.red_in, cmd.green_in, cmd.blue_in};
      x = load_pos % w;
      row = load_pos / w;
      load_pos++;
      if (x == w - 1)
        for (int unsigned i = 0; i < w; i++)
          hblur_mem[row * w + i] = blur_axis(1'b0, row * w, i, w, 1);
    end else begin
      total = w * clamp(out_rows_reg, 1, 128);
      if (drain_pos >= total) drain_pos = 0;  // stale position restarts
      x = drain_pos % w;
      row = first_row_reg + drain_pos / w;
      px = (row < eff_rows() || radius_reg > 0)
           ? blur_axis(1'b1, x, row, eff_rows(), w) : 24'd0;
      exp_pix.out_column = x[8:0];
      exp_pix.out_row    = row[6:0];
      exp_pix.red_out    = px[23:16];
      exp_pix.green_out  = px[15:8];
      exp_pix.blue_out   = px[7:0];
      exp_pix.last       = (drain_pos == total - 1);
      expected_pixels.push_back(exp_pix);
      if (exp_pix.last) begin
        drain_pos = 0;
        load_pos = 0;
      end else begin
        drain_pos++;
      end
    end
  endfunction

  // Driver: issues commands in bursts with random gaps. start stays high
  // until the transfer happens, and is assigned once per clock edge.
  always @(posedge clk) begin
    logic         next_start;
    pending_cmd_t p;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        predict_command(in_item);
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].hold && expected_pixels.size() > 0)) begin
          p = cmd_queue.pop_front();
          in_item <= p.item;
          next_start = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // Some bursts run back to back, the rest leave a gap behind them.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end
      end
    end
    start <= next_start;
  end

  // Monitor: a result is valid for exactly one cycle and is taken at once.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel out with nothing expected: %p", out_item);
        fail_count++;
      end else begin
        e = expected_pixels.pop_front();
        if (out_item.out_column !== e.out_column) begin
          $error("out_column expected %0d got %0d", e.out_column, out_item.out_column);
          fail_count++;
        end
        if (out_item.out_row !== e.out_row) begin
          $error("out_row expected %0d got %0d", e.out_row, out_item.out_row);
          fail_count++;
        end
        if (out_item.red_out !== e.red_out) begin
          $error("red_out expected %0d got %0d", e.red_out, out_item.red_out);
          fail_count++;
        end
        if (out_item.green_out !== e.green_out) begin
          $error("green_out expected %0d got %0d", e.green_out, out_item.green_out);
          fail_count++;
        end
        if (out_item.blue_out !== e.blue_out) begin
          $error("blue_out expected %0d got %0d", e.blue_out, out_item.blue_out);
          fail_count++;
        end
        if (out_item.last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("separable_blur_strip_tb NOT OK");
      $finish;
    end
  end

  // Waits until every command went in, every pixel came out and busy has
  // stayed low, so that a trailing horizontal pass is over.
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 4) begin
      @(posedge clk);
      if (cmd_queue.size() == 0 && !start && expected_pixels.size() == 0 && !busy)
        quiet++;
      else
        quiet = 0;
    end
    repeat (8) @(posedge clk);
  endtask

  // Writes all eight registers on consecutive edges and mirrors them.
  task automatic write_config(logic [63:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= vals[i];
      case (cfg_idx_t'(i))
        CFG_IMAGE_WIDTH:   width_reg = vals[i][9:0];
        CFG_STRIP_ROWS:    rows_reg = vals[i][7:0];
        CFG_FIRST_OUT_ROW: first_row_reg = vals[i][6:0];
        CFG_OUT_ROWS:      out_rows_reg = vals[i][7:0];
        CFG_RADIUS:        radius_reg = vals[i][3:0];
        CFG_WEIGHTS_LOW:   weight_reg[0] = vals[i];
        CFG_WEIGHTS_MID:   weight_reg[1] = vals[i];
        CFG_WEIGHTS_HIGH:  weight_reg[2] = vals[i];
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(cmd_t op, logic [23:0] rgb, bit hold);
    pending_cmd_t p;
    p.item.command = op;
    {p.item.red_in, p.item.green_in, p.item.blue_in} = rgb;
    p.hold = hold;
    cmd_queue.push_back(p);
    item_count++;
  endtask

  function automatic logic [23:0] rand_rgb();
    return 24'($urandom);
  endfunction

  // One full strip: configure, load every pixel (plus some ignored extras),
  // then drain the whole output range so that both positions wrap to zero.
  // pattern 1 alternates black and white pixels instead of random ones.
  task automatic run_strip(logic [63:0] vals[8], int extra, bit pattern);
    int unsigned n_load;
    int unsigned n_drain;
    int unsigned hold_at;
    wait_idle();
    write_config(vals);
    n_load = eff_width() * eff_rows();
    n_drain = eff_width() * clamp(out_rows_reg, 1, 128);
    for (int unsigned i = 0; i < n_load + extra; i++)
      push_cmd(CMD_LOAD, pattern ? ((i % 2) ? 24'hFFFFFF : 24'h000000) : rand_rgb(), 1'b0);
    hold_at = $urandom_range(0, n_drain - 1);
    for (int unsigned i = 0; i < n_drain; i++)
      push_cmd(CMD_DRAIN, rand_rgb(), i == hold_at);
  endtask

  function automatic logic [63:0] rand_weights();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: begin
        v = {$urandom, $urandom};
        for (int l = 0; l < 4; l++)
          if ($urandom_range(0, 3) == 0) v[16 * l +: 16] = '0;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] cfg[8];

    width_reg = 10'd512;
    rows_reg = 8'd128;
    first_row_reg = '0;
    out_rows_reg = 8'd128;
    radius_reg = '0;
    weight_reg = '{64'd32768, 64'd0, 64'd0};
    load_pos = 0;
    drain_pos = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Small strip of black and white pixels under a narrow smoothing kernel.
    cfg = '{3, 3, 0, 3, 1, 64'h0000_0000_4000_8000, 0, 0};
    run_strip(cfg, 0, 1'b1);
    // All weights zero: every channel comes out zero.
    cfg = '{4, 2, 0, 2, 2, 0, 0, 0};
    run_strip(cfg, 1, 1'b0);
    // Clamped registers: width 0, rows 0, out rows 0, radius above the maximum,
    // and every weight at its largest value.
    cfg = '{0, 0, 0, 0, 15, '1, '1, '1};
    run_strip(cfg, 2, 1'b1);
    // Output rows far beyond the strip with radius zero, then a range running past it with radius.
    cfg = '{2, 2, 127, 1, 0, 64'h8000, 0, 0};
    run_strip(cfg, 0, 1'b0);
    cfg = '{3, 4, 2, 4, 11, 64'h1234_5678_9ABC_DEF0, 64'h0F0F_F0F0_0001_FFFF,
            64'hFFFF_0001_8000_7FFF};
    run_strip(cfg, 0, 1'b0);

    // Drain part of a range, then shrink the range below the drain position:
    // the next drain starts again at the beginning of the range.
    wait_idle();
    cfg = '{4, 3, 0, 3, 1, 64'h0000_0000_2000_4000, 0, 0};
    write_config(cfg);
    for (int i = 0; i < 12; i++) push_cmd(CMD_LOAD, rand_rgb(), 1'b0);
    for (int i = 0; i < 7; i++) push_cmd(CMD_DRAIN, rand_rgb(), 1'b0);
    wait_idle();
    cfg[CFG_OUT_ROWS] = 64'd1;
    write_config(cfg);
    for (int i = 0; i < 4; i++) push_cmd(CMD_DRAIN, rand_rgb(), 1'b0);

    // Widest strip: width register above the maximum clamps to 512, one row.
    // Only the start of the range is drained; a one-pixel range then makes the
    // stale drain position restart and end the range.
    wait_idle();
    cfg = '{1023, 1, 0, 1, 11, rand_weights(), rand_weights(), rand_weights()};
    write_config(cfg);
    for (int i = 0; i < 515; i++) push_cmd(CMD_LOAD, rand_rgb(), 1'b0);
    for (int i = 0; i < 40; i++) push_cmd(CMD_DRAIN, rand_rgb(), 1'b0);
    wait_idle();
    cfg[CFG_IMAGE_WIDTH] = 64'd1;
    write_config(cfg);
    push_cmd(CMD_DRAIN, rand_rgb(), 1'b0);

    // Random strips, mostly small so that the horizontal passes stay short.
    while (item_count < 850) begin
      cfg[CFG_IMAGE_WIDTH]   = 64'($urandom_range(0, 12));
      cfg[CFG_STRIP_ROWS]    = 64'($urandom_range(0, 6));
      cfg[CFG_FIRST_OUT_ROW] = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 127))
                                                          : 64'($urandom_range(0, 4));
      cfg[CFG_OUT_ROWS]      = 64'($urandom_range(0, 5));
      cfg[CFG_RADIUS]        = 64'($urandom_range(0, 15));
      cfg[CFG_WEIGHTS_LOW]   = rand_weights();
      cfg[CFG_WEIGHTS_MID]   = rand_weights();
      cfg[CFG_WEIGHTS_HIGH]  = rand_weights();
      run_strip(cfg, $urandom_range(0, 2), 1'b0);
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("separable_blur_strip_tb OK");
    end else begin
      $display("separable_blur_strip_tb NOT OK");
    end
    $finish;
  end

endmodule
